// ===== sv/u16u8_pkg.sv =====
package u16u8_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;
  localparam logic [20:0] Replace   = 21'h00FFFD;
  localparam logic [20:0] SuppBase  = 21'h010000;
  localparam logic [20:0] Lim1Byte  = 21'h000080;
  localparam logic [20:0] Lim2Byte  = 21'h000800;
  localparam logic [20:0] Lim3Byte  = 21'h010000;
  localparam logic [5:0]  HighTag   = 6'b110110;

  localparam logic [1:0] Len1 = 2'd0;
  localparam logic [1:0] Len2 = 2'd1;
  localparam logic [1:0] Len3 = 2'd2;
  localparam logic [1:0] Len4 = 2'd3;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       run_last;
    logic       string_end;
  } out_t;

  typedef struct packed {
    logic        raw_valid;
    logic [9:0]  raw_bits;
    logic        main_valid;
    logic [1:0]  main_len_m1;
    logic [20:0] main_cp;
    logic        last;
  } job_t;

  typedef enum logic {
    PhRaw,
    PhMain
  } phase_e;

  function automatic logic [1:0] len_m1_f(logic [20:0] cp);
    logic [1:0] len;
    if (cp < Lim1Byte) begin
      len = Len1;
    end else if (cp < Lim2Byte) begin
      len = Len2;
    end else if (cp < Lim3Byte) begin
      len = Len3;
    end else begin
      len = Len4;
    end
    return len;
  endfunction

  function automatic logic [7:0] utf8_byte_f(logic [20:0] cp, logic [1:0] len_m1,
                                             logic [1:0] idx);
    logic [7:0] b;
    b = {2'b10, cp[5:0]};
    unique case (len_m1)
      Len1: b = {1'b0, cp[6:0]};
      Len2: begin
        if (idx == 2'd0) begin
          b = {3'b110, cp[10:6]};
        end
      end
      Len3: begin
        unique case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// ===== sv/utf16_to_utf8_transcoder.sv =====
// Channel   Handshake        Payload                               Direction
// input     push / full      in_i  : code_unit[15:0], last_unit    into block
// result    empty / pop      out_o : utf8_byte[7:0], run_last,     out of block
//                                    string_end
//
// One input unit per cycle while the job queue has room; bytes leave one per cycle while pop is held.
// A unit yields 0 to 6 bytes (1 to 3 for BMP text, 4 for a pair), and the byte
// sequencer, which emits them in turn, sets the sustained rate.
// The first byte of a unit passes through the job queue and the working register to the output register on out_o.
// Reset clears the held surrogate, the job queue and the output register.
// A stalled pop holds the output register; full rises only when the queue fills.
module utf16_to_utf8_transcoder import u16u8_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_t  in_i,
  output logic empty,
  input  logic pop,
  output out_t out_o
);

  logic q_wr, q_full, q_rd, q_empty;
  job_t q_wr_job, q_rd_job;

  u16u8_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_wr_o   (q_wr),
    .q_job_o  (q_wr_job)
  );

  u16u8_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_job_i (q_wr_job),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .rd_job_o (q_rd_job),
    .empty_o  (q_empty)
  );

  u16u8_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_job_i   (q_rd_job),
    .q_rd_o    (q_rd),
    .empty     (empty),
    .pop       (pop),
    .out_o     (out_o)
  );

endmodule

// ===== sv/u16u8_front.sv =====
module u16u8_front import u16u8_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_t  in_i,
  input  logic q_full_i,
  output logic q_wr_o,
  output job_t q_job_o
);

  logic       held_q, held_d;
  logic [9:0] held_bits_q, held_bits_d;
  logic       accept;
  logic       is_high, is_low;
  logic [15:0] u;
  job_t       job;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;
  assign u      = in_i.code_unit;
  assign is_high = (u >= HighFirst) && (u <= HighLast);
  assign is_low  = (u >= LowFirst) && (u <= LowLast);

  always_comb begin
    job         = '0;
    job.last    = in_i.last_unit;
    held_d      = held_q;
    held_bits_d = held_bits_q;
    if (accept) begin
      held_d = 1'b0;
      if (held_q && is_low) begin
        job.main_valid = 1'b1;
        job.main_cp    = SuppBase + {1'b0, held_bits_q, u[9:0]};
      end else begin
        if (held_q) begin
          job.raw_valid = 1'b1;
          job.raw_bits  = held_bits_q;
        end
        if (is_high && !in_i.last_unit) begin
          held_d      = 1'b1;
          held_bits_d = u[9:0];
        end else if (is_high || is_low) begin
          job.main_valid = 1'b1;
          job.main_cp    = Replace;
        end else begin
          job.main_valid = 1'b1;
          job.main_cp    = {5'b0, u};
        end
      end
      job.main_len_m1 = len_m1_f(job.main_cp);
    end
  end

  assign q_wr_o  = accept && (job.raw_valid || job.main_valid);
  assign q_job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      held_bits_q <= '0;
    end else begin
      held_q      <= held_d;
      held_bits_q <= held_bits_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.last_unit |-> q_wr_o)
    else $error("final unit produced no job");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.last_unit |=> !held_q)
    else $error("surrogate held past end of string");

endmodule

// ===== sv/u16u8_fifo.sv =====
module u16u8_fifo import u16u8_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_job_i,
  output logic full_o,
  input  logic rd_i,
  output job_t rd_job_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o   = count_q == CntW'(Depth);
  assign empty_o  = count_q == '0;
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_job_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_rd) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && full_o))
    else $error("write into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_wr && !do_rd |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count lost a write");

endmodule

// ===== sv/u16u8_back.sv =====
module u16u8_back import u16u8_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  job_t q_job_i,
  output logic q_rd_o,
  output logic empty,
  input  logic pop,
  output out_t out_o
);

  job_t       w_q, w_d;
  logic       w_valid_q, w_valid_d;
  phase_e     phase_q, phase_d;
  logic [1:0] idx_q, idx_d;
  out_t       out_q, out_d;
  logic       out_valid_q, out_valid_d;

  logic        slot_free, gen, load;
  logic        phase_end, item_end;
  logic [20:0] cp_sel;
  logic [1:0]  len_sel;

  assign cp_sel  = (phase_q == PhRaw) ? {5'b0, HighTag, w_q.raw_bits} : w_q.main_cp;
  assign len_sel = (phase_q == PhRaw) ? Len3 : w_q.main_len_m1;

  assign slot_free = !out_valid_q || pop;
  assign gen       = w_valid_q && slot_free;
  assign phase_end = idx_q == len_sel;
  assign item_end  = phase_end && ((phase_q == PhMain) || !w_q.main_valid);
  assign load      = !q_empty_i && (!w_valid_q || (gen && item_end));
  assign q_rd_o    = load;

  always_comb begin
    w_d         = w_q;
    w_valid_d   = w_valid_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (load) begin
      w_d       = q_job_i;
      w_valid_d = 1'b1;
      phase_d   = q_job_i.raw_valid ? PhRaw : PhMain;
      idx_d     = '0;
    end else if (gen && item_end) begin
      w_valid_d = 1'b0;
    end else if (gen) begin
      if (phase_end) begin
        phase_d = PhMain;
        idx_d   = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (gen) begin
      out_valid_d      = 1'b1;
      out_d.utf8_byte  = utf8_byte_f(cp_sel, len_sel, idx_q);
      out_d.run_last   = item_end;
      out_d.string_end = item_end && w_q.last;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q   <= 1'b0;
      phase_q     <= PhMain;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      w_valid_q   <= w_valid_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    out_q <= out_d;
  end

  assign empty = !out_valid_q;
  assign out_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.string_end |-> out_q.run_last)
    else $error("string end without run end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_valid_q && (phase_q == PhRaw) |-> w_q.raw_valid)
    else $error("raw phase on job without held surrogate");

endmodule

// ===== sim/tb_utf16_to_utf8_transcoder.sv =====
`timescale 1ns / 100ps

module tb_utf16_to_utf8_transcoder;
  import u16u8_pkg::*;

  localparam int unsigned ItemTarget = 330;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainGuard = 20000;
  localparam int unsigned TailCycles = 12;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  in_t  in_i;
  logic empty;
  logic pop;
  out_t out_o;

  utf16_to_utf8_transcoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

  out_t        utf8_bytes_due[$];
  logic        surr_held;
  logic [9:0]  surr_high_bits;
  int unsigned units_sent;
  int unsigned fail_count;
  int unsigned cycle_count;
  logic        tx_idle_on;
  logic        rx_idle_on;
  int unsigned hold_req_seq;
  int unsigned hold_ack_seq;
  int unsigned hold_left;
  out_t        want_byte;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void push_code_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      utf8_bytes_due.push_back('{utf8_byte: cp[7:0], run_last: 1'b0, string_end: 1'b0});
    end else if (cp < 21'h800) begin
      utf8_bytes_due.push_back('{utf8_byte: {3'b110, cp[10:6]}, run_last: 1'b0,
                                 string_end: 1'b0});
      utf8_bytes_due.push_back('{utf8_byte: {2'b10, cp[5:0]}, run_last: 1'b0,
                                 string_end: 1'b0});
    end else if (cp < 21'h10000) begin
      utf8_bytes_due.push_back('{utf8_byte: {4'b1110, cp[15:12]}, run_last: 1'b0,
                                 string_end: 1'b0});
      utf8_bytes_due.push_back('{utf8_byte: {2'b10, cp[11:6]}, run_last: 1'b0,
                                 string_end: 1'b0});
      utf8_bytes_due.push_back('{utf8_byte: {2'b10, cp[5:0]}, run_last: 1'b0,
                                 string_end: 1'b0});
    end else begin
      utf8_bytes_due.push_back('{utf8_byte: {5'b11110, cp[20:18]}, run_last: 1'b0,
                                 string_end: 1'b0});
      utf8_bytes_due.push_back('{utf8_byte: {2'b10, cp[17:12]}, run_last: 1'b0,
                                 string_end: 1'b0});
      utf8_bytes_due.push_back('{utf8_byte: {2'b10, cp[11:6]}, run_last: 1'b0,
                                 string_end: 1'b0});
      utf8_bytes_due.push_back('{utf8_byte: {2'b10, cp[5:0]}, run_last: 1'b0,
                                 string_end: 1'b0});
    end
  endfunction

  function automatic void predict_utf8(in_t item);
    logic [15:0] u;
    logic        is_high;
    logic        is_low;
    logic        paired;
    int          first;
    out_t        tail;
    u       = item.code_unit;
    is_high = (u >= HighFirst) && (u <= HighLast);
    is_low  = (u >= LowFirst) && (u <= LowLast);
    paired  = 1'b0;
    first   = utf8_bytes_due.size();
    if (surr_held) begin
      surr_held = 1'b0;
      if (is_low) begin
        push_code_point(21'h10000 + {1'b0, surr_high_bits, 10'b0} + {11'b0, u[9:0]});
        paired = 1'b1;
      end else begin
        push_code_point({5'b0, 6'b110110, surr_high_bits});
      end
      surr_high_bits = 10'd0;
    end
    if (!paired) begin
      if (is_high && !item.last_unit) begin
        surr_held      = 1'b1;
        surr_high_bits = u[9:0];
      end else if (is_high || is_low) begin
        push_code_point(21'h00FFFD);
      end else begin
        push_code_point({5'b0, u});
      end
    end
    if (utf8_bytes_due.size() > first) begin
      tail            = utf8_bytes_due.pop_back();
      tail.run_last   = 1'b1;
      tail.string_end = item.last_unit;
      utf8_bytes_due.push_back(tail);
    end
  endfunction

  task automatic send_unit(logic [15:0] unit, logic last);
    in_t item;
    item.code_unit = unit;
    item.last_unit = last;
    if (tx_idle_on) begin
      while ($urandom_range(99) < 26) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push <= 1'b1;
    in_i <= item;
    do @(posedge clk_i); while (full);
    predict_utf8(item);
    units_sent++;
  endtask

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    push <= 1'b0;
    while ((utf8_bytes_due.size() != 0) && (guard < DrainGuard)) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TailCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_bmp_3byte();
    if ($urandom_range(1)) return 16'($urandom_range(16'hD7FF, 16'h0800));
    return 16'($urandom_range(16'hFFFF, 16'hE000));
  endfunction

  task automatic send_random_string();
    int unsigned len;
    int unsigned kind;
    logic        noisy;
    logic        at_end;
    len   = $urandom_range(8, 1);
    noisy = ($urandom_range(99) < 20);
    for (int unsigned i = 0; i < len; i++) begin
      at_end = (i == len - 1);
      kind   = $urandom_range(9);
      if (noisy) begin
        send_unit(16'($urandom), 1'($urandom_range(1)));
      end else begin
        unique case (kind)
          0, 1, 2: send_unit(16'($urandom_range(16'h007F, 16'h0000)), at_end);
          3, 4:    send_unit(16'($urandom_range(16'h07FF, 16'h0080)), at_end);
          5, 6:    send_unit(pick_bmp_3byte(), at_end);
          7, 8: begin
            send_unit(16'($urandom_range(HighLast, HighFirst)), 1'b0);
            send_unit(16'($urandom_range(LowLast, LowFirst)), at_end);
          end
          default: begin
            if ($urandom_range(1)) begin
              send_unit(16'($urandom_range(HighLast, HighFirst)), at_end);
            end else begin
              send_unit(16'($urandom_range(LowLast, LowFirst)), at_end);
            end
          end
        endcase
      end
    end
  endtask

  task automatic test_directed();
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b1);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'hD834, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(16'hDC05, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDBFF, 1'b1);
    send_unit(16'hD9AB, 1'b1);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'hD812, 1'b0);
    send_unit(16'h20AC, 1'b1);
    send_unit(16'hFFFD, 1'b1);
  endtask

  task automatic test_backpressure();
    int unsigned stop_at;
    stop_at = units_sent + 40;
    hold_req_seq <= hold_req_seq + 1;
    while (units_sent < stop_at) send_random_string();
  endtask

  task automatic test_drain_pause();
    send_unit(16'h0391, 1'b0);
    send_unit(16'hDA3C, 1'b0);
    wait_drained();
    send_unit(16'hDE21, 1'b0);
    send_unit(16'hD83D, 1'b0);
    wait_drained();
    send_unit(16'h0062, 1'b1);
    wait_drained();
  endtask

  task automatic test_no_idle_stretch();
    int unsigned stop_at;
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    stop_at = units_sent + 90;
    while (units_sent < stop_at) send_random_string();
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
  endtask

  task automatic test_random_traffic();
    while (units_sent < ItemTarget) send_random_string();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop          <= 1'b0;
      hold_ack_seq <= 0;
      hold_left    <= 0;
    end else begin
      if (pop && !empty) begin
        if (utf8_bytes_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected byte: got %02h run_last %0b string_end %0b",
                     out_o.utf8_byte, out_o.run_last, out_o.string_end);
          end
        end else begin
          want_byte = utf8_bytes_due.pop_front();
          if ((out_o.utf8_byte !== want_byte.utf8_byte) ||
              (out_o.run_last !== want_byte.run_last) ||
              (out_o.string_end !== want_byte.string_end)) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("byte mismatch: utf8_byte exp %02h got %02h, run_last exp %0b got %0b, %s",
                       want_byte.utf8_byte, out_o.utf8_byte, want_byte.run_last,
                       out_o.run_last,
                       $sformatf("string_end exp %0b got %0b", want_byte.string_end,
                                 out_o.string_end));
            end
          end
        end
      end
      if (hold_req_seq != hold_ack_seq) begin
        hold_ack_seq <= hold_req_seq;
        hold_left    <= HoldCycles;
        pop          <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else begin
        pop <= !(rx_idle_on && ($urandom_range(99) < 26));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("utf16_to_utf8_transcoder verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    push           = 1'b0;
    in_i           = '0;
    surr_held      = 1'b0;
    surr_high_bits = 10'd0;
    units_sent     = 0;
    fail_count     = 0;
    cycle_count    = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    hold_req_seq   = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_drain_pause();
    test_backpressure();
    test_no_idle_stretch();
    test_random_traffic();
    wait_drained();

    if (utf8_bytes_due.size() != 0) begin
      fail_count++;
      $display("%0d bytes never arrived", utf8_bytes_due.size());
    end
    if (fail_count == 0) begin
      $display("utf16_to_utf8_transcoder verification clean");
    end else begin
      $display("utf16_to_utf8_transcoder verification failed");
    end
    $finish;
  end

endmodule
